// ===== hw/rtl/fpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants and types for the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int DEF_DATA_WIDTH = 32;
    localparam int DEF_FRAC_BITS  = 8;
    localparam int PORT_WIDTH     = 32;

    typedef logic [3:0] op_t;

    localparam op_t OP_ADD      = 4'd0;
    localparam op_t OP_SUB      = 4'd1;
    localparam op_t OP_MUL      = 4'd2;
    localparam op_t OP_DIV      = 4'd3;
    localparam op_t OP_MIN      = 4'd4;
    localparam op_t OP_MAX      = 4'd5;
    localparam op_t OP_INC      = 4'd6;
    localparam op_t OP_DEC      = 4'd7;
    localparam op_t OP_FROM_INT = 4'd8;
    localparam op_t OP_TO_INT   = 4'd9;

    // Per-beat side information that rides next to the divider.
    typedef struct packed {
        logic is_div;
        logic dbz;
        logic lt;
        logic eq;
        logic gt;
    } flags_t;

endpackage

// ===== hw/rtl/fpa_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_divider
// Pipelined restoring divider, two quotient bits per stage. Computes
// (|a| << FRAC_BITS) / |b|, applies the sign and truncates to DATA_WIDTH.
// ----------------------------------------------------------------------------
module fpa_divider #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [DATA_WIDTH-1:0] dividend_mag,
    input  logic [DATA_WIDTH-1:0] divisor_mag,
    input  logic                  neg,
    output logic [DATA_WIDTH-1:0] quotient
);
    localparam int QW  = DATA_WIDTH + FRAC_BITS;
    localparam int NST = (QW + 1) / 2;
    localparam int PW  = 2 * NST;

    logic [DATA_WIDTH-1:0] rem_reg  [NST];
    logic [PW-1:0]         work_reg [NST];
    logic [DATA_WIDTH-1:0] dvs_reg  [NST];
    logic                  neg_reg  [NST];

    logic [DATA_WIDTH-1:0] rem_next  [NST];
    logic [PW-1:0]         work_next [NST];

    genvar s;
    generate
        for (s = 0; s < NST; s++)
        begin : g_stage
            logic [DATA_WIDTH-1:0] rem_in;
            logic [PW-1:0]         work_in;
            logic [DATA_WIDTH-1:0] dvs_in;

            if (s == 0)
            begin : g_first
                assign rem_in  = '0;
                assign work_in = PW'({dividend_mag, {FRAC_BITS{1'b0}}});
                assign dvs_in  = divisor_mag;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[s-1];
                assign work_in = work_reg[s-1];
                assign dvs_in  = dvs_reg[s-1];
            end

            always_comb
            begin
                logic [DATA_WIDTH:0]   t;
                logic [DATA_WIDTH-1:0] r;
                logic [PW-1:0]         w;
                r = rem_in;
                w = work_in;
                for (int k = 0; k < 2; k++)
                begin
                    t = {r, w[PW-1]};
                    if (t >= {1'b0, dvs_in})
                    begin
                        t = t - {1'b0, dvs_in};
                        w = {w[PW-2:0], 1'b1};
                    end
                    else
                    begin
                        w = {w[PW-2:0], 1'b0};
                    end
                    r = t[DATA_WIDTH-1:0];
                end
                rem_next[s]  = r;
                work_next[s] = w;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s]  <= rem_next[s];
                    work_reg[s] <= work_next[s];
                    dvs_reg[s]  <= dvs_in;
                    neg_reg[s]  <= (s == 0) ? neg : neg_reg[s == 0 ? 0 : s-1];
                end
            end
        end
    endgenerate

    logic [DATA_WIDTH-1:0] q_mag;
    assign q_mag    = work_reg[NST-1][DATA_WIDTH-1:0];
    assign quotient = neg_reg[NST-1] ? (~q_mag + 1'b1) : q_mag;

endmodule

// ===== hw/rtl/fixed_point_q24_8_alu.sv =====
`timescale 1ns / 1ps
// Depth is set by the divider, which resolves two quotient bits per stage.
// Throughput: one beat per cycle while the output is not stalled; every
//   operation travels the same pipeline.
// A stall at the output freezes the whole pipeline in place.
// Reset (rst_n low, asynchronous) clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Signed Q24.8 fixed-point ALU with comparison flags, fully pipelined.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu #(
    parameter int DATA_WIDTH = fpa_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = fpa_pkg::DEF_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  fpa_pkg::op_t                   req_type,
    input  logic signed [fpa_pkg::PORT_WIDTH-1:0] operand_a,
    input  logic signed [fpa_pkg::PORT_WIDTH-1:0] operand_b,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [fpa_pkg::PORT_WIDTH-1:0] result_value,
    output logic                           a_less,
    output logic                           a_equal,
    output logic                           a_greater,
    output logic                           divide_by_zero
);
    import fpa_pkg::*;

    localparam int QW  = DATA_WIDTH + FRAC_BITS;
    localparam int NST = (QW + 1) / 2;
    localparam int W   = DATA_WIDTH;

    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // ---------------- stage 1: capture operands ----------------
    logic                v1_reg;
    op_t                 op1_reg;
    logic signed [W-1:0] a1_reg;
    logic signed [W-1:0] b1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg <= req_type;
            a1_reg  <= operand_a[W-1:0];
            b1_reg  <= operand_b[W-1:0];
        end
    end

    // ---------------- stage 2: simple ops, multiply, flags ----------------
    logic signed [2*W-1:0] product;
    logic signed [2*W-1:0] prod_sh;
    logic signed [W-1:0]   res2_next;
    flags_t                fl2_next;

    assign product = a1_reg * b1_reg;
    assign prod_sh = product >>> FRAC_BITS;

    always_comb
    begin
        fl2_next.lt     = a1_reg < b1_reg;
        fl2_next.eq     = a1_reg == b1_reg;
        fl2_next.gt     = a1_reg > b1_reg;
        fl2_next.is_div = op1_reg == OP_DIV;
        fl2_next.dbz    = (op1_reg == OP_DIV) && (b1_reg == '0);
        case (op1_reg)
            OP_ADD:      res2_next = a1_reg + b1_reg;
            OP_SUB:      res2_next = a1_reg - b1_reg;
            OP_MUL:      res2_next = prod_sh[W-1:0];
            OP_MIN:      res2_next = (a1_reg < b1_reg) ? a1_reg : b1_reg;
            OP_MAX:      res2_next = (a1_reg > b1_reg) ? a1_reg : b1_reg;
            OP_INC:      res2_next = a1_reg + 1'b1;
            OP_DEC:      res2_next = a1_reg - 1'b1;
            OP_FROM_INT: res2_next = a1_reg <<< FRAC_BITS;
            OP_TO_INT:   res2_next = a1_reg >>> FRAC_BITS;
            default:     res2_next = '0;
        endcase
    end

    // Divider runs alongside the delay line below.
    logic [W-1:0] a_mag;
    logic [W-1:0] b_mag;
    logic [W-1:0] div_q;

    assign a_mag = a1_reg[W-1] ? (~a1_reg + 1'b1) : a1_reg;
    assign b_mag = b1_reg[W-1] ? (~b1_reg + 1'b1) : b1_reg;

    fpa_divider #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk          (clk),
        .en           (en),
        .dividend_mag (a_mag),
        .divisor_mag  (b_mag),
        .neg          (a1_reg[W-1] ^ b1_reg[W-1]),
        .quotient     (div_q)
    );

    // ---------------- delay line aligned with the divider ----------------
    logic                pv_reg  [NST];
    logic signed [W-1:0] res_reg [NST];
    flags_t              fl_reg  [NST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
                pv_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            pv_reg[0] <= v1_reg;
            for (int i = 1; i < NST; i++)
                pv_reg[i] <= pv_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg[0] <= res2_next;
            fl_reg[0]  <= fl2_next;
            for (int i = 1; i < NST; i++)
            begin
                res_reg[i] <= res_reg[i-1];
                fl_reg[i]  <= fl_reg[i-1];
            end
        end
    end

    // ---------------- output stage ----------------
    logic                out_valid_reg;
    logic signed [W-1:0] out_res_reg;
    flags_t              out_fl_reg;
    logic signed [W-1:0] final_next;
    flags_t              fl_last;

    assign fl_last = fl_reg[NST-1];

    always_comb
    begin
        if (fl_last.dbz)
            final_next = '0;
        else if (fl_last.is_div)
            final_next = div_q;
        else
            final_next = res_reg[NST-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= pv_reg[NST-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_res_reg <= final_next;
            out_fl_reg  <= fl_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_value   = PORT_WIDTH'(out_res_reg);
    assign a_less         = out_fl_reg.lt;
    assign a_equal        = out_fl_reg.eq;
    assign a_greater      = out_fl_reg.gt;
    assign divide_by_zero = out_fl_reg.dbz;

    // ---------------- assertions ----------------
    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> result_value == '0)
        else $error("divide by zero beat carries a nonzero result");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot({a_less, a_equal, a_greater}))
        else $error("comparison flags not exactly one hot");

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall out of step with output stall");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v1_reg) && $stable(pv_reg[NST-1]))
        else $error("pipeline advanced while stalled");

endmodule

// ===== test/fixed_point_q24_8_alu_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_test
// Self-checking bench for the Q24.8 ALU: directed corner operands, then
// random beats under several idle/stall mixes, checked against a predictor.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_test;
    import fpa_pkg::*;

    localparam int FRAC = DEF_FRAC_BITS;

    typedef struct {
        logic [31:0] value;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        dbz;
    } alu_result_t;

    int unsigned mismatches = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    class alu_scoreboard;
        alu_result_t pending[$];
        int unsigned checked = 0;

        function automatic alu_result_t compute(op_t op, logic signed [31:0] a,
                                                logic signed [31:0] b);
            alu_result_t r;
            logic signed [63:0] wa, wb, wide;
            wa = a;
            wb = b;
            wide = 0;
            r.dbz = 1'b0;
            case (op)
                OP_ADD:      wide = wa + wb;
                OP_SUB:      wide = wa - wb;
                OP_MUL:      wide = (wa * wb) >>> FRAC;
                OP_DIV:
                    if (b == 0) r.dbz = 1'b1;
                    else        wide = (wa <<< FRAC) / wb;
                OP_MIN:      wide = (wa < wb) ? wa : wb;
                OP_MAX:      wide = (wa > wb) ? wa : wb;
                OP_INC:      wide = wa + 1;
                OP_DEC:      wide = wa - 1;
                OP_FROM_INT: wide = wa <<< FRAC;
                OP_TO_INT:   wide = wa >>> FRAC;
                default:     wide = 0;
            endcase
            r.value = wide[31:0];
            r.lt = a < b;
            r.eq = a == b;
            r.gt = a > b;
            return r;
        endfunction

        function void note_input(op_t op, logic signed [31:0] a, logic signed [31:0] b);
            pending.push_back(compute(op, a, b));
        endfunction

        task check_result(alu_result_t got);
            alu_result_t want;
            checked++;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected beat", got.value, 32'h0);
                return;
            end
            want = pending.pop_front();
            if (got.value !== want.value) report_mismatch("result_value", got.value, want.value);
            if (got.lt !== want.lt) report_mismatch("a_less", got.lt, want.lt);
            if (got.eq !== want.eq) report_mismatch("a_equal", got.eq, want.eq);
            if (got.gt !== want.gt) report_mismatch("a_greater", got.gt, want.gt);
            if (got.dbz !== want.dbz) report_mismatch("divide_by_zero", got.dbz, want.dbz);
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    op_t                req_type = OP_ADD;
    logic signed [31:0] operand_a = '0;
    logic signed [31:0] operand_b = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] result_value;
    logic               a_less, a_equal, a_greater, divide_by_zero;

    alu_scoreboard expected_results = new();
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_stall_pct = 0;
    int unsigned   hold_off_cycles = 0;
    int unsigned   beats_sent = 0;

    fixed_point_q24_8_alu DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_value(result_value), .a_less(a_less), .a_equal(a_equal),
        .a_greater(a_greater), .divide_by_zero(divide_by_zero)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d results outstanding", expected_results.pending.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random stall, or a long hold-off when requested.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            alu_result_t got;
            got.value = result_value;
            got.lt = a_less;
            got.eq = a_equal;
            got.gt = a_greater;
            got.dbz = divide_by_zero;
            expected_results.check_result(got);
        end
        if (hold_off_cycles != 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Drive one beat; hold it until accepted.
    task automatic send_beat(input op_t op, input logic [31:0] a, input logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= op;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_results.note_input(op, a, b);
        beats_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.pending.size() != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] random_operand();
        case ($urandom_range(7))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7fff_ffff - $urandom_range(3);
            2: return $urandom_range(4) - 2;
            3: return $signed($urandom_range(8191)) - 4096;
            4: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic random_beats(input int unsigned count);
        logic [31:0] a, b;
        op_t         op;
        repeat (count)
        begin
            a = random_operand();
            b = ($urandom_range(9) == 0) ? a : random_operand();
            op = ($urandom_range(19) == 0) ? op_t'($urandom_range(15, 10))
                                           : op_t'($urandom_range(9));
            send_beat(op, a, b);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every defined op code on corner operands, plus two undefined codes.
        send_beat(OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
        send_beat(OP_SUB, 32'h8000_0000, 32'h0000_0001);
        send_beat(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
        send_beat(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_beat(OP_MUL, 32'hffff_ffff, 32'h0000_0001);
        send_beat(OP_DIV, 32'h0000_0100, 32'h0000_0000);
        send_beat(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_beat(OP_DIV, 32'hffff_ff00, 32'h0000_0300);
        send_beat(OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
        send_beat(OP_MIN, 32'h8000_0000, 32'h7fff_ffff);
        send_beat(OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
        send_beat(OP_MIN, 32'h1234_5678, 32'h1234_5678);
        send_beat(OP_INC, 32'h7fff_ffff, 32'h0);
        send_beat(OP_DEC, 32'h8000_0000, 32'h0);
        send_beat(OP_FROM_INT, 32'h0080_0000, 32'hffff_ffff);
        send_beat(OP_FROM_INT, 32'hff7f_ffff, 32'h0);
        send_beat(OP_TO_INT, 32'hffff_ffff, 32'h1);
        send_beat(OP_TO_INT, 32'h8000_0000, 32'h0);
        send_beat(op_t'(4'd10), 32'h5, 32'h3);
        send_beat(op_t'(4'd15), 32'hffff_ffff, 32'hffff_ffff);
        drain();

        random_beats(200);
        send_idle_pct = 72;
        random_beats(150);
        send_idle_pct = 0;
        recv_stall_pct = 72;
        random_beats(150);
        send_idle_pct = 19;
        recv_stall_pct = 19;
        random_beats(150);

        // Fill the pipeline against a long output hold-off.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 60;
        random_beats(100);
        drain();
        random_beats(100);
        drain();

        repeat (30) @(posedge clk);
        $display("sent %0d beats, checked %0d results over all op codes and idle mixes",
                 beats_sent, expected_results.checked);
        if (mismatches == 0 && expected_results.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
